// File: sv/tcgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgs_pkg
// Shared types and constants of the three-channel gate step sequencer.
// ----------------------------------------------------------------------------
package tcgs_pkg;

    localparam int STEPS        = 16;
    localparam int CHANNELS     = 3;
    localparam int IDX_W        = $clog2(STEPS);
    localparam int CS_W         = $clog2(STEPS + 1);
    localparam int STEP_COUNT_W = 5;
    localparam int TIME_W       = 16;
    localparam int DIV_W        = 8;
    localparam int DIV_OUT_W    = 4;
    localparam int LED_W        = 4;
    localparam int CFG_W        = 16;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [DIV_W-1:0] DIV_FULL  = 8'hFF;
    localparam logic [CFG_W-1:0] DTW_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] SDH_RESET = 16'd4000;

    localparam logic REG_DOUBLE_TAP_WINDOW = 1'b0;
    localparam logic REG_STEP_DISPLAY_HOLD = 1'b1;

    localparam logic [1:0] DIV_CODE_A = 2'd0;
    localparam logic [1:0] DIV_CODE_B = 2'd1;
    localparam logic [1:0] DIV_CODE_C = 2'd2;
    localparam logic [1:0] DIV_CODE_D = 2'd3;

    typedef struct packed {
        logic                    run_mode;
        logic                    shift_button;
        logic [CHANNELS-1:0]     channel_buttons;
        logic                    external_clock_select;
        logic                    clock_in_level;
        logic [TIME_W-1:0]       elapsed_count;
        logic [TIME_W-1:0]       internal_period;
        logic [STEP_COUNT_W-1:0] step_count;
        logic [1:0]              divider_base_raw;
    } t_in_item;

    typedef struct packed {
        logic [CHANNELS-1:0]  gate_outputs;
        logic                 clock_out;
        logic                 clock_pin_drives;
        logic [DIV_OUT_W-1:0] divider_outputs;
        logic [LED_W-1:0]     step_leds;
        logic                 timer_restart;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] double_tap_window;
        logic [CFG_W-1:0] step_display_hold;
    } t_cfg;

    function automatic logic [1:0] divider_shift(input logic [1:0] raw);
        logic [1:0] sh;
        sh = 2'd0;
        unique case (raw)
            DIV_CODE_A, DIV_CODE_B: sh = 2'd0;
            DIV_CODE_D:             sh = 2'd1;
            DIV_CODE_C:             sh = 2'd2;
        endcase
        return sh;
    endfunction

endpackage
`default_nettype wire

// File: sv/tcgs_apb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgs_apb_regs
// Configuration registers of the sequencer behind an APB-style port.
// ----------------------------------------------------------------------------
module tcgs_apb_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tcgs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tcgs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tcgs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output tcgs_pkg::t_cfg                        o_cfg
);
    import tcgs_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_tap_window <= DTW_RESET;
            r_cfg.step_display_hold <= SDH_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_DOUBLE_TAP_WINDOW: r_cfg.double_tap_window <= pwdata[CFG_W-1:0];
                REG_STEP_DISPLAY_HOLD: r_cfg.step_display_hold <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_DOUBLE_TAP_WINDOW: prdata = APB_DATA_W'(r_cfg.double_tap_window);
            REG_STEP_DISPLAY_HOLD: prdata = APB_DATA_W'(r_cfg.step_display_hold);
        endcase
    end

endmodule
`default_nettype wire

// File: sv/tcgs_frame.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcgs_frame
// Sequencer state and the per-frame update logic: tick detection, step
// advance, pattern editing, gate, clock, divider and LED outputs.
// ----------------------------------------------------------------------------
module tcgs_frame (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire tcgs_pkg::t_in_item   i_item,
    input  wire tcgs_pkg::t_cfg       i_cfg,
    output tcgs_pkg::t_out_item       o_result
);
    import tcgs_pkg::*;

    logic [CHANNELS-1:0]  r_pat [STEPS];
    logic [CS_W-1:0]      r_cs;
    logic [DIV_W-1:0]     r_div;
    logic [CS_W-1:0]      r_lsc;
    logic [CFG_W-1:0]     r_dhl;
    logic [CFG_W-1:0]     r_dtl;
    logic                 r_lse;
    logic                 r_lcl;
    logic [TIME_W-1:0]    r_lp;
    logic                 r_lsh;
    logic [CHANNELS-1:0]  r_lb;
    logic                 r_cko;
    logic [DIV_OUT_W-1:0] r_dl;
    logic [LED_W-1:0]     r_led;

    logic [CS_W-1:0]      n_cs;
    logic [DIV_W-1:0]     n_div;
    logic [CS_W-1:0]      n_lsc;
    logic [CFG_W-1:0]     n_dhl;
    logic [CFG_W-1:0]     n_dtl;
    logic                 n_lcl;
    logic [TIME_W-1:0]    n_lp;
    logic                 n_cko;
    logic [DIV_OUT_W-1:0] n_dl;
    logic [LED_W-1:0]     n_led;
    logic [CHANNELS-1:0]  n_row;
    logic [IDX_W-1:0]     idx;
    logic [CHANNELS-1:0]  gates;
    logic                 tick;

    function automatic logic [CS_W-1:0] step_inc(input logic [CS_W-1:0] cs,
                                                 input logic [CS_W-1:0] lim);
        logic [CS_W:0] t;
        t = {1'b0, cs} + 1'b1;
        return (t >= {1'b0, lim}) ? '0 : t[CS_W-1:0];
    endfunction

    always_comb begin
        logic [CS_W-1:0]     steps_c;
        logic [CFG_W-1:0]    dt_dec;
        logic                edge_sh;
        logic                run;
        logic                ext;
        logic [DIV_W-1:0]    div1;
        logic [DIV_W-1:0]    div2;
        logic [TIME_W-1:0]   half_lp;
        logic [CHANNELS-1:0] row;
        logic                gate_on;

        run     = i_item.run_mode;
        ext     = i_item.external_clock_select;
        half_lp = {1'b0, r_lp[TIME_W-1:1]};

        if (i_item.step_count == '0) begin
            steps_c = CS_W'(1);
        end else if (int'(i_item.step_count) > STEPS) begin
            steps_c = CS_W'(STEPS);
        end else begin
            steps_c = CS_W'(i_item.step_count);
        end

        dt_dec = (r_dtl != '0) ? r_dtl - 1'b1 : r_dtl;

        n_lsc = r_lsc;
        n_dhl = r_dhl;
        n_led = r_led;
        if (steps_c != r_lsc) begin
            n_lsc = steps_c;
            n_dhl = i_cfg.step_display_hold;
        end else if (r_dhl != '0) begin
            n_dhl = r_dhl - 1'b1;
            n_led = LED_W'(steps_c);
        end

        edge_sh = i_item.shift_button & ~r_lsh;
        n_cs    = r_cs;
        div1    = r_div;
        n_dtl   = dt_dec;
        if (edge_sh && run) begin
            if (dt_dec != '0) begin
                n_cs = steps_c;
                div1 = DIV_FULL;
            end
            n_dtl = i_cfg.double_tap_window;
        end

        n_cko = (ext && !r_lse) ? 1'b0 : r_cko;

        n_lcl = r_lcl;
        if (ext) begin
            tick  = i_item.clock_in_level & ~r_lcl;
            n_lcl = i_item.clock_in_level;
        end else begin
            tick = (run && edge_sh) || (i_item.elapsed_count > i_item.internal_period);
        end

        if (!run && edge_sh) begin
            n_cs = step_inc(r_cs, steps_c);
        end

        idx = (n_cs == CS_W'(STEPS)) ? '0 : n_cs[IDX_W-1:0];
        row = r_pat[idx];
        for (int i = 0; i < CHANNELS; i++) begin
            if (i_item.channel_buttons[i] && (i_item.shift_button || !r_lb[i])) begin
                if (run) begin
                    row[i] = ~i_item.shift_button;
                end else begin
                    row[i] = ~row[i];
                end
            end
        end
        n_row   = row;
        gate_on = !run || (i_item.elapsed_count < half_lp);
        gates   = gate_on ? row : '0;

        div2  = div1 + 1'b1;
        n_div = div1;
        n_lp  = r_lp;
        n_dl  = r_dl;
        if (tick) begin
            n_div = div2;
            if (run) begin
                n_cs = step_inc(n_cs, steps_c);
            end
            n_lp = i_item.elapsed_count;
            if (!ext) begin
                n_cko = 1'b1;
            end
            n_dl = DIV_OUT_W'((div2 ^ div1) >> divider_shift(i_item.divider_base_raw));
        end else if (i_item.elapsed_count > half_lp) begin
            if (!ext) begin
                n_cko = 1'b0;
            end
            n_dl = '0;
        end

        if (n_dhl == '0) begin
            n_led = LED_W'(n_cs);
        end

        o_result.gate_outputs     = gates;
        o_result.clock_out        = ~ext & n_cko;
        o_result.clock_pin_drives = ~ext;
        o_result.divider_outputs  = n_dl;
        o_result.step_leds        = n_led;
        o_result.timer_restart    = tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STEPS; i++) begin
                r_pat[i] <= '0;
            end
            r_cs  <= '0;
            r_div <= '0;
            r_lsc <= CS_W'(1);
            r_dhl <= '0;
            r_dtl <= '0;
            r_lse <= 1'b0;
            r_lcl <= 1'b0;
            r_lp  <= '0;
            r_lsh <= 1'b0;
            r_lb  <= '0;
            r_cko <= 1'b0;
            r_dl  <= '0;
            r_led <= '0;
        end else if (i_en) begin
            r_pat[idx] <= n_row;
            r_cs  <= n_cs;
            r_div <= n_div;
            r_lsc <= n_lsc;
            r_dhl <= n_dhl;
            r_dtl <= n_dtl;
            r_lse <= i_item.external_clock_select;
            r_lcl <= n_lcl;
            r_lp  <= n_lp;
            r_lsh <= i_item.shift_button;
            r_lb  <= i_item.channel_buttons;
            r_cko <= n_cko;
            r_dl  <= n_dl;
            r_led <= n_led;
        end
    end

endmodule
`default_nettype wire

// File: sv/three_channel_gate_step_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_channel_gate_step_sequencer_top
// Each item is one poll frame of a three-channel, 16-step gate sequencer.
// The block takes one item per clock while its result output is not stalled
// and returns exactly one result item for each. An item passes through an
// input register, the frame logic and a result register; the single update
// of the sequencer state per frame sets that rate. The pattern store is held
// in flip-flops and is cleared at reset, so the block is ready right after
// reset. The two configuration registers are written over the APB-style
// port; the user must write them only while the block is idle, as the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module three_channel_gate_step_sequencer_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire tcgs_pkg::t_in_item               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output tcgs_pkg::t_out_item                   o_out_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tcgs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tcgs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tcgs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import tcgs_pkg::*;

    t_cfg      cfg;
    t_in_item  r_in_data;
    logic      r_in_vld;
    logic      n_in_vld;
    t_out_item r_out_data;
    logic      r_out_vld;
    logic      n_out_vld;
    t_out_item result;
    logic      proc;
    logic      in_acc;

    tcgs_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcgs_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (proc),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign proc       = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_in_vld & ~proc;
    assign in_acc     = i_in_valid & ~o_in_stall;

    always_comb begin
        n_in_vld  = in_acc ? 1'b1 : (proc ? 1'b0 : r_in_vld);
        n_out_vld = proc ? 1'b1 : (i_out_stall ? r_out_vld : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_data <= i_in_data;
        end
        if (proc) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the three-channel gate step sequencer.
// The driver sends poll frames from a queue. A short directed list comes
// first, then long runs of frames whose buttons, clocks and timer evolve
// like real use. The driver predicts each result with its own model of the
// sequencer state at the edge where it hands a frame over. The monitor
// compares every result, field by field, with the oldest prediction. Both
// sides pause at random. Between phases the two registers are rewritten
// over the APB port and read back.
// ----------------------------------------------------------------------------
module tb;
    import tcgs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    t_in_item              in_data  = '0;
    logic                  out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    three_channel_gate_step_sequencer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // Sequencer model state.
    logic [CFG_W-1:0]    tap_window;
    logic [CFG_W-1:0]    display_hold;
    logic [CHANNELS-1:0] pattern_bits [STEPS];
    int unsigned         cur_step;
    logic [DIV_W-1:0]    div_count;
    int unsigned         last_count;
    logic [TIME_W-1:0]   hold_left;
    logic [TIME_W-1:0]   tap_left;
    logic                last_ext;
    logic                last_clk_in;
    logic [TIME_W-1:0]   last_period;
    logic                last_shift;
    logic [CHANNELS-1:0] last_btn;
    logic                clk_level;
    logic [DIV_OUT_W-1:0] div_latch;
    logic [LED_W-1:0]    led_latch;

    t_in_item    pending_frames[$];
    t_out_item   expected_outputs[$];
    t_out_item   predicted;
    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_settings = 1;
    int unsigned n_ticks = 0;
    int unsigned n_loop_resets = 0;
    int unsigned n_manual_steps = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    // Slowly changing front-panel state for the random frames.
    logic                g_run = 1'b1;
    logic                g_shift = 1'b0;
    logic [CHANNELS-1:0] g_btn = '0;
    logic                g_ext = 1'b0;
    logic                g_clk_in = 1'b0;
    logic [TIME_W-1:0]   g_timer = '0;
    logic [TIME_W-1:0]   g_period = 16'd20;
    logic [STEP_COUNT_W-1:0] g_steps = 5'd8;
    logic [1:0]          g_base = DIV_CODE_A;

    task automatic reset_model();
        tap_window   = DTW_RESET;
        display_hold = SDH_RESET;
        for (int i = 0; i < STEPS; i++) pattern_bits[i] = '0;
        cur_step    = 0;
        div_count   = '0;
        last_count  = 1;
        hold_left   = '0;
        tap_left    = '0;
        last_ext    = 1'b0;
        last_clk_in = 1'b0;
        last_period = '0;
        last_shift  = 1'b0;
        last_btn    = '0;
        clk_level   = 1'b0;
        div_latch   = '0;
        led_latch   = '0;
    endtask

    task automatic run_frame(input t_in_item f, output t_out_item r);
        int unsigned         steps;
        int unsigned         idx;
        int unsigned         base_shift;
        logic                rise;
        logic                tick;
        logic [CHANNELS-1:0] gates;
        logic [DIV_W-1:0]    prev_div;
        steps = f.step_count;
        if (steps < 1) steps = 1;
        if (steps > STEPS) steps = STEPS;
        case (f.divider_base_raw)
            DIV_CODE_D: base_shift = 1;
            DIV_CODE_C: base_shift = 2;
            default:    base_shift = 0;
        endcase
        gates = '0;

        if (tap_left > 0) tap_left--;
        if (steps != last_count) begin
            last_count = steps;
            hold_left  = display_hold;
        end else if (hold_left > 0) begin
            hold_left--;
            led_latch = LED_W'(steps);
        end

        rise = f.shift_button && !last_shift;
        last_shift = f.shift_button;
        if (rise && f.run_mode) begin
            if (tap_left > 0) begin
                cur_step  = steps;
                div_count = DIV_FULL;
                n_loop_resets++;
            end
            tap_left = tap_window;
        end

        if (f.external_clock_select != last_ext) begin
            if (f.external_clock_select) clk_level = 1'b0;
            last_ext = f.external_clock_select;
        end

        if (f.external_clock_select) begin
            tick = f.clock_in_level && !last_clk_in;
            last_clk_in = f.clock_in_level;
        end else begin
            tick = (f.run_mode && rise) || (f.elapsed_count > f.internal_period);
        end

        if (!f.run_mode && rise) begin
            cur_step++;
            if (cur_step >= steps) cur_step = 0;
            n_manual_steps++;
        end

        idx = cur_step % STEPS;
        for (int i = 0; i < CHANNELS; i++) begin
            if (f.channel_buttons[i] && (f.shift_button || !last_btn[i])) begin
                if (!f.run_mode) pattern_bits[idx][i] = !pattern_bits[idx][i];
                else pattern_bits[idx][i] = !f.shift_button;
            end
            if (pattern_bits[idx][i] && (!f.run_mode || f.elapsed_count < last_period / 2))
                gates[i] = 1'b1;
        end
        last_btn = f.channel_buttons;

        if (tick) begin
            prev_div  = div_count;
            div_count = div_count + 1'b1;
            if (f.run_mode) begin
                cur_step++;
                if (cur_step >= steps) cur_step = 0;
            end
            last_period = f.elapsed_count;
            if (!f.external_clock_select) clk_level = 1'b1;
            div_latch = DIV_OUT_W'((div_count ^ prev_div) >> base_shift);
            n_ticks++;
        end else if (f.elapsed_count > last_period / 2) begin
            if (!f.external_clock_select) clk_level = 1'b0;
            div_latch = '0;
        end

        if (hold_left == 0) led_latch = LED_W'(cur_step);

        r.gate_outputs     = gates;
        r.clock_out        = !f.external_clock_select && clk_level;
        r.clock_pin_drives = !f.external_clock_select;
        r.divider_outputs  = div_latch;
        r.step_leds        = led_latch;
        r.timer_restart    = tick;
    endtask

    function automatic int unsigned idle_length(input bit calm);
        int unsigned pick;
        if (calm) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item frame(
        input logic run, input logic shift, input logic [CHANNELS-1:0] btn,
        input logic ext, input logic clk_in, input logic [TIME_W-1:0] timer,
        input logic [TIME_W-1:0] period, input logic [STEP_COUNT_W-1:0] steps,
        input logic [1:0] base
    );
        t_in_item f;
        f.run_mode              = run;
        f.shift_button          = shift;
        f.channel_buttons       = btn;
        f.external_clock_select = ext;
        f.clock_in_level        = clk_in;
        f.elapsed_count         = timer;
        f.internal_period       = period;
        f.step_count            = steps;
        f.divider_base_raw      = base;
        return f;
    endfunction

    task automatic queue_frame(input t_in_item f);
        pending_frames.push_back(f);
        n_queued++;
    endtask

    task automatic add_random_frames(input int unsigned n);
        logic [$bits(t_in_item)-1:0] noise;
        int unsigned                 pick;
        repeat (n) begin
            if ($urandom_range(0, 39) == 0) g_run = !g_run;
            if ($urandom_range(0, 3) == 0) g_shift = !g_shift;
            for (int i = 0; i < CHANNELS; i++)
                if ($urandom_range(0, 5) == 0) g_btn[i] = !g_btn[i];
            if ($urandom_range(0, 59) == 0) g_ext = !g_ext;
            if ($urandom_range(0, 2) == 0) g_clk_in = !g_clk_in;
            if ($urandom_range(0, 49) == 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) g_period = '0;
                else if (pick == 1) g_period = '1;
                else if (pick < 4) g_period = TIME_W'($urandom);
                else g_period = TIME_W'($urandom_range(1, 40));
            end
            if ($urandom_range(0, 29) == 0) g_timer = TIME_W'($urandom);
            else if (g_timer > g_period) g_timer = '0;
            else g_timer = g_timer + TIME_W'($urandom_range(0, 3));
            if ($urandom_range(0, 39) == 0) begin
                if ($urandom_range(0, 3) == 0) g_steps = STEP_COUNT_W'($urandom_range(0, 31));
                else g_steps = STEP_COUNT_W'($urandom_range(1, STEPS));
            end
            if ($urandom_range(0, 19) == 0) g_base = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 19) == 0) begin
                noise = $bits(t_in_item)'({$urandom, $urandom});
                queue_frame(t_in_item'(noise));
            end else begin
                queue_frame(frame(g_run, g_shift, g_btn, g_ext, g_clk_in, g_timer,
                                  g_period, g_steps, g_base));
            end
        end
    endtask

    task automatic settle();
        while (n_accepted != n_queued || expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata[CFG_W-1:0] !== value) begin
            $display("%0t: register %0d read back: expected %0d, actual %0d",
                     $time, idx, value, prdata[CFG_W-1:0]);
            mismatches++;
        end
        if (idx == REG_DOUBLE_TAP_WINDOW) tap_window = value;
        else display_hold = value;
        n_settings++;
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s: expected %0d, actual %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (in_valid && !o_in_stall) begin
            run_frame(in_data, predicted);
            expected_outputs.push_back(predicted);
            n_accepted++;
        end
        if (!in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= pending_frames.pop_front();
                send_gap = idle_length(send_calm);
                if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t: result with no frame pending: actual %h", $time, o_out_data);
                mismatches++;
            end else begin
                want = expected_outputs.pop_front();
                check_field("gate_outputs", want.gate_outputs, o_out_data.gate_outputs);
                check_field("clock_out", want.clock_out, o_out_data.clock_out);
                check_field("clock_pin_drives", want.clock_pin_drives,
                            o_out_data.clock_pin_drives);
                check_field("divider_outputs", want.divider_outputs,
                            o_out_data.divider_outputs);
                check_field("step_leds", want.step_leds, o_out_data.step_leds);
                check_field("timer_restart", want.timer_restart, o_out_data.timer_restart);
                n_checked++;
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) stall_left = idle_length(recv_calm);
            if ($urandom_range(0, 99) == 0) recv_calm = !recv_calm;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // Edits at the first step, double taps on both clock sources, manual stepping.
        queue_frame(frame(1, 0, 3'b000, 0, 0, 16'd0, 16'd0, 5'd4, DIV_CODE_A));
        queue_frame(frame(1, 0, 3'b111, 0, 0, 16'd0, 16'hFFFF, 5'd4, DIV_CODE_A));
        queue_frame(frame(1, 1, 3'b101, 0, 0, 16'd0, 16'hFFFF, 5'd4, DIV_CODE_A));
        queue_frame(frame(1, 0, 3'b000, 0, 0, 16'd1, 16'hFFFF, 5'd4, DIV_CODE_A));
        queue_frame(frame(1, 1, 3'b000, 0, 0, 16'd2, 16'hFFFF, 5'd4, DIV_CODE_A));
        queue_frame(frame(1, 0, 3'b000, 1, 0, 16'd3, 16'hFFFF, 5'd16, DIV_CODE_A));
        queue_frame(frame(1, 1, 3'b000, 1, 1, 16'd4, 16'hFFFF, 5'd16, DIV_CODE_A));
        queue_frame(frame(1, 0, 3'b000, 1, 0, 16'd5, 16'hFFFF, 5'd16, DIV_CODE_A));
        queue_frame(frame(1, 1, 3'b000, 1, 0, 16'd6, 16'hFFFF, 5'd16, DIV_CODE_A));
        queue_frame(frame(1, 0, 3'b110, 1, 0, 16'd7, 16'hFFFF, 5'd16, DIV_CODE_A));
        queue_frame(frame(1, 0, 3'b010, 1, 1, 16'd8, 16'hFFFF, 5'd16, DIV_CODE_A));
        queue_frame(frame(0, 0, 3'b000, 1, 0, 16'd9, 16'hFFFF, 5'd16, DIV_CODE_B));
        queue_frame(frame(0, 1, 3'b000, 1, 0, 16'd10, 16'hFFFF, 5'd16, DIV_CODE_B));
        queue_frame(frame(0, 0, 3'b011, 1, 0, 16'd11, 16'hFFFF, 5'd16, DIV_CODE_B));
        queue_frame(frame(0, 0, 3'b011, 1, 0, 16'd12, 16'hFFFF, 5'd16, DIV_CODE_B));
        queue_frame(frame(0, 0, 3'b000, 1, 0, 16'd13, 16'hFFFF, 5'd16, DIV_CODE_B));
        queue_frame(frame(0, 0, 3'b011, 1, 0, 16'd14, 16'hFFFF, 5'd16, DIV_CODE_B));
        queue_frame(frame(1, 0, 3'b000, 0, 0, 16'hFFFF, 16'd0, 5'd0, DIV_CODE_D));
        queue_frame(frame(1, 0, 3'b000, 0, 0, 16'hFFFF, 16'd0, 5'd31, DIV_CODE_C));
        queue_frame(frame(1, 0, 3'b000, 0, 0, 16'hFFFF, 16'd0, 5'd17, DIV_CODE_B));
        queue_frame(frame(1, 0, 3'b000, 0, 0, 16'd40000, 16'hFFFF, 5'd16, DIV_CODE_A));
        queue_frame(frame(1, 0, 3'b000, 0, 0, 16'd10, 16'hFFFF, 5'd16, DIV_CODE_A));
        queue_frame(frame(0, 0, 3'b111, 0, 1, 16'd0, 16'd0, 5'd1, DIV_CODE_A));
        add_random_frames(250);
        settle();

        set_reg(REG_DOUBLE_TAP_WINDOW, 16'd0);
        set_reg(REG_STEP_DISPLAY_HOLD, 16'd0);
        add_random_frames(200);
        settle();

        set_reg(REG_DOUBLE_TAP_WINDOW, 16'hFFFF);
        set_reg(REG_STEP_DISPLAY_HOLD, 16'hFFFF);
        add_random_frames(150);
        settle();

        set_reg(REG_DOUBLE_TAP_WINDOW, CFG_W'($urandom_range(2, 30)));
        set_reg(REG_STEP_DISPLAY_HOLD, CFG_W'($urandom_range(1, 60)));
        add_random_frames(200);
        settle();

        set_reg(REG_DOUBLE_TAP_WINDOW, CFG_W'($urandom));
        set_reg(REG_STEP_DISPLAY_HOLD, CFG_W'($urandom));
        add_random_frames(150);
        settle();

        $display("tb: %0d frames sent, %0d results checked under %0d register settings",
                 n_accepted, n_checked, n_settings);
        $display("tb: %0d ticks, %0d double-tap loop resets, %0d manual steps, %0d mismatches",
                 n_ticks, n_loop_resets, n_manual_steps, mismatches);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
